FILE: rtl/mcpwm_pkg.sv
// ----------------------------------------------------------------------------
// Multichannel PWM package
// Word types, register indexes and constants shared by the PWM driver files.
// ----------------------------------------------------------------------------
package mcpwm_pkg;

    // Channel count and the fixed width of the packed channel output field.
    localparam int DEF_CHANNELS  = 17;
    localparam int OUT_CH_W      = 17;
    localparam int LEVEL_W       = 8;
    localparam int CHAN_IDX_W    = 8;
    localparam int DIV_W         = 16;
    localparam int PERIOD_W      = 32;
    localparam int CFG_IDX_W     = 1;
    localparam int CFG_DATA_W    = 32;

    // Request types of an input word.
    localparam logic REQ_TICK    = 1'b0;
    localparam logic REQ_CMD     = 1'b1;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PHASE_DIV  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHECK_PER  = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [DIV_W-1:0]    PHASE_DIV_RST  = 16'd1;
    localparam logic [PERIOD_W-1:0] CHECK_PER_RST  = 32'd125;

    // Input word: one tick or one level command.
    typedef struct packed {
        logic                  req_type;
        logic [CHAN_IDX_W-1:0] channel_index;
        logic [LEVEL_W-1:0]    level_value;
        logic                  link_up;
    } t_in_word;

    // Result word: channel levels and keepalive requests.
    typedef struct packed {
        logic [OUT_CH_W-1:0] channel_outputs;
        logic                ping_request;
        logic                reconnect_request;
    } t_out_word;

    // Configuration write as seen by the core.
    typedef struct packed {
        logic                  wr_en;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

FILE: rtl/mcpwm_core.sv
// ----------------------------------------------------------------------------
// Multichannel PWM core
// Holds the channel levels, output states, frame phase and keepalive counters,
// and works out the result word of one accepted input word in a single pass.
// ----------------------------------------------------------------------------
module mcpwm_core
    import mcpwm_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  t_in_word  i_word,
    input  t_cfg_wr   i_cfg,
    output t_out_word o_result
);

    localparam logic [CHAN_IDX_W-1:0] CHAN_LIMIT = CHAN_IDX_W'(CHANNELS);

    // State registers.
    logic [LEVEL_W-1:0]  r_levels [CHANNELS];
    logic [CHANNELS-1:0] r_high;
    logic [7:0]          r_phase;
    logic [DIV_W-1:0]    r_prescale;
    logic [PERIOD_W-1:0] r_check;
    logic                r_ping_pending;
    logic [DIV_W-1:0]    r_phase_div;
    logic [PERIOD_W-1:0] r_check_per;

    logic [DIV_W-1:0]    div_eff;
    logic [PERIOD_W-1:0] per_eff;
    logic [DIV_W:0]      prescale_inc;
    logic [PERIOD_W:0]   check_inc;
    logic                step;
    logic                check_due;
    logic [7:0]          n_phase;
    logic                frame_wrap;
    logic [CHANNELS-1:0] high_base;
    logic [CHANNELS-1:0] drop;
    logic [CHANNELS-1:0] n_high;
    logic [CHANNELS-1:0] shown_high;
    logic                is_tick;
    logic                chan_ok;

    // A zero divider or period behaves as one.
    assign div_eff = (r_phase_div == '0) ? DIV_W'(1) : r_phase_div;
    assign per_eff = (r_check_per == '0) ? PERIOD_W'(1) : r_check_per;

    // Prescaler and frame phase.
    assign prescale_inc = {1'b0, r_prescale} + (DIV_W+1)'(1);
    assign step         = prescale_inc >= {1'b0, div_eff};
    assign n_phase      = step ? r_phase + 8'd1 : r_phase;
    assign frame_wrap   = step && (r_phase == 8'hFF);

    // Keepalive check counter.
    assign check_inc = {1'b0, r_check} + (PERIOD_W+1)'(1);
    assign check_due = check_inc >= {1'b0, per_eff};

    assign is_tick = (i_word.req_type == REQ_TICK);
    assign chan_ok = i_word.channel_index < CHAN_LIMIT;

    // A channel drops low once phase + level passes full scale.
    always_comb begin
        for (int n = 0; n < CHANNELS; n++) begin
            high_base[n] = frame_wrap | r_high[n];
            drop[n]      = 9'({1'b0, n_phase} + {1'b0, r_levels[n]}) > 9'd255;
        end
    end
    assign n_high     = high_base & ~drop;
    assign shown_high = is_tick ? n_high : r_high;

    // Result word, channels beyond the output field are dropped.
    always_comb begin
        o_result = '0;
        for (int b = 0; b < OUT_CH_W; b++) begin
            if (b < CHANNELS) begin
                o_result.channel_outputs[b] = shown_high[b];
            end
        end
        if (is_tick && check_due) begin
            o_result.ping_request      = !r_ping_pending & i_word.link_up;
            o_result.reconnect_request = r_ping_pending;
        end
    end

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_div <= PHASE_DIV_RST;
            r_check_per <= CHECK_PER_RST;
        end else if (i_cfg.wr_en) begin
            unique case (i_cfg.index)
                CFG_PHASE_DIV: r_phase_div <= i_cfg.data[DIV_W-1:0];
                CFG_CHECK_PER: r_check_per <= i_cfg.data[PERIOD_W-1:0];
                default:       ;
            endcase
        end
    end

    // Timing state, advanced by tick words; a command word clears the pending ping.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high         <= '1;
            r_phase        <= '0;
            r_prescale     <= '0;
            r_check        <= '0;
            r_ping_pending <= 1'b0;
        end else if (i_accept) begin
            if (is_tick) begin
                r_high     <= n_high;
                r_phase    <= n_phase;
                r_prescale <= step ? '0 : prescale_inc[DIV_W-1:0];
                if (check_due) begin
                    r_check        <= '0;
                    r_ping_pending <= !r_ping_pending;
                end else begin
                    r_check <= check_inc[PERIOD_W-1:0];
                end
            end else begin
                r_ping_pending <= 1'b0;
            end
        end
    end

    // Channel levels, written by commands to a channel in range.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int n = 0; n < CHANNELS; n++) begin
                r_levels[n] <= '0;
            end
        end else if (i_accept && !is_tick && chan_ok) begin
            for (int n = 0; n < CHANNELS; n++) begin
                if (i_word.channel_index == CHAN_IDX_W'(n)) begin
                    r_levels[n] <= i_word.level_value;
                end
            end
        end
    end

endmodule

FILE: rtl/multichannel_pwm_with_keepalive_top.sv
// ----------------------------------------------------------------------------
// Multichannel PWM driver with link keepalive
// Top level: input and configuration ports, the PWM core and a two-word
// output buffer of result register plus skid register.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake            | word
//  ---------+-----------+----------------------+--------------------------
//  in       | input     | i_in_valid/o_in_stall   | t_in_word (tick or cmd)
//  out      | output    | o_out_valid/i_out_stall | t_out_word (one per in)
//  cfg      | input     | i_cfg_valid/o_cfg_ready | index and 32-bit data
//
// Each accepted word is worked combinationally into the result or skid register;
// one word per cycle is sustained while the output is not stalled.
// The result register and skid register let one result wait while the next
// word is taken; o_in_stall rises only when both are full.
// Reset is synchronous and spares only the buffer payload; cfg is always ready.
module multichannel_pwm_with_keepalive_top
    import mcpwm_pkg::*;
#(
    parameter int CHANNELS = DEF_CHANNELS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  t_in_word              i_in_word,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output t_out_word             o_out_word,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic      in_acc;
    logic      out_acc;
    t_cfg_wr   cfg_wr;
    t_out_word result;

    logic      r_out_valid;
    t_out_word r_out_word;
    logic      r_skid_valid;
    t_out_word r_skid_word;

    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_acc     = r_out_valid && !i_out_stall;
    assign o_in_stall  = r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign o_cfg_ready = 1'b1;

    assign cfg_wr.wr_en = i_cfg_valid && o_cfg_ready;
    assign cfg_wr.index = i_cfg_index;
    assign cfg_wr.data  = i_cfg_data;

    // PWM state and single-pass result logic.
    mcpwm_core #(
        .CHANNELS (CHANNELS)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_acc),
        .i_word   (i_in_word),
        .i_cfg    (cfg_wr),
        .o_result (result)
    );

    // Output buffer: the skid register fills only when the result register waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_acc) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= in_acc;
            end
        end else if (in_acc) begin
            if (r_out_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end
    end

    // Buffer payload.
    always_ff @(posedge i_clk) begin
        if (out_acc) begin
            r_out_word <= r_skid_valid ? r_skid_word : result;
        end else if (in_acc) begin
            if (r_out_valid) begin
                r_skid_word <= result;
            end else begin
                r_out_word <= result;
            end
        end
    end

endmodule

FILE: rtl/mcpwm_checker.sv
// ----------------------------------------------------------------------------
// Multichannel PWM port checker
// Watches the top level's ports and flags buffer and keepalive slips.
// ----------------------------------------------------------------------------
module mcpwm_checker
    import mcpwm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // A waiting result word stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result word withdrawn while stalled");

    // The input side is stalled only while a result is waiting.
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with an empty output");

    // After an accepted word, a result word is always offered in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_out_valid)
        else $error("accepted word produced no result");

    // A single check never asks for both a ping and a reconnect.
    a_req_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.ping_request && o_out_word.reconnect_request))
        else $error("ping and reconnect requested together");

endmodule

bind multichannel_pwm_with_keepalive_top mcpwm_checker u_checker (.*);

FILE: test/multichannel_pwm_with_keepalive_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Multichannel PWM driver testbench
// Drives tick and level-command words into the PWM driver under random
// idling on both sides, keeps its own copy of the channel levels, frame
// phase, prescaler and keepalive state, and checks every result word field
// by field against that copy. Register settings change between phases.
// ----------------------------------------------------------------------------
module multichannel_pwm_with_keepalive_top_tb;
    import mcpwm_pkg::*;

    localparam int NCH         = DEF_CHANNELS;
    localparam int HOLD_CYCLES = 64;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    t_in_word              i_in_word;
    logic                  o_out_valid;
    logic                  i_out_stall;
    t_out_word             o_out_word;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    // Predicted state of the driver.
    logic [LEVEL_W-1:0]  chan_level [NCH];
    logic [OUT_CH_W-1:0] chan_high;
    logic [7:0]          frame_phase;
    logic [DIV_W-1:0]    prescale_cnt;
    logic [PERIOD_W-1:0] keepalive_cnt;
    logic                ping_outstanding;
    logic [DIV_W-1:0]    phase_div_reg;
    logic [PERIOD_W-1:0] check_per_reg;

    t_out_word pending_pwm_words [$];
    int        mismatch_count = 0;
    logic      no_idle = 1'b0;
    logic      hold_start = 1'b0;
    int        hold_left = 0;

    multichannel_pwm_with_keepalive_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Advance the predicted state by one word and return the result it gives.
    function automatic t_out_word next_pwm_word(input t_in_word w);
        t_out_word        r;
        logic [DIV_W:0]   next_pre;
        logic [PERIOD_W:0] next_chk;
        logic [DIV_W-1:0] div_eff;
        logic [PERIOD_W-1:0] per_eff;
        r = '0;
        if (w.req_type == REQ_CMD) begin
            ping_outstanding = 1'b0;
            if (w.channel_index < NCH)
                chan_level[w.channel_index] = w.level_value;
        end else begin
            div_eff = (phase_div_reg == '0) ? DIV_W'(1) : phase_div_reg;
            per_eff = (check_per_reg == '0) ? PERIOD_W'(1) : check_per_reg;
            next_pre = {1'b0, prescale_cnt} + 1'b1;
            if (next_pre >= {1'b0, div_eff}) begin
                prescale_cnt = '0;
                frame_phase  = frame_phase + 8'd1;
                // A new frame starts with every channel high.
                if (frame_phase == 8'd0)
                    chan_high = '1;
            end else begin
                prescale_cnt = next_pre[DIV_W-1:0];
            end
            for (int n = 0; n < NCH; n++) begin
                if (chan_high[n] && ({1'b0, frame_phase} > (9'd255 - {1'b0, chan_level[n]})))
                    chan_high[n] = 1'b0;
            end
            next_chk = {1'b0, keepalive_cnt} + 1'b1;
            if (next_chk >= {1'b0, per_eff}) begin
                keepalive_cnt = '0;
                if (!ping_outstanding) begin
                    ping_outstanding = 1'b1;
                    r.ping_request   = w.link_up;
                end else begin
                    r.reconnect_request = 1'b1;
                    ping_outstanding    = 1'b0;
                end
            end else begin
                keepalive_cnt = next_chk[PERIOD_W-1:0];
            end
        end
        r.channel_outputs = chan_high;
        return r;
    endfunction

    // Offer one word, wait for it to be taken and record its expected result.
    task automatic send_word(input t_in_word w);
        while (!no_idle && ($urandom_range(99) < 17)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        pending_pwm_words.push_back(next_pwm_word(w));
    endtask

    // Stop offering words until every expected result has come out.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pwm_words.size() != 0)
            @(posedge i_clk);
        @(posedge i_clk);
    endtask

    // Write both registers back to back; only called while the block is idle.
    task automatic write_registers(input logic [DIV_W-1:0] div,
                                   input logic [PERIOD_W-1:0] per);
        logic [15:0] junk;
        junk = 16'($urandom);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_PHASE_DIV;
        i_cfg_data  <= {junk, div};
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_index <= CFG_CHECK_PER;
        i_cfg_data  <= per;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid   <= 1'b0;
        phase_div_reg = div;
        check_per_reg = per;
    endtask

    function automatic t_in_word make_tick(input logic link);
        t_in_word w;
        w.req_type      = REQ_TICK;
        w.channel_index = 8'($urandom);
        w.level_value   = 8'($urandom);
        w.link_up       = link;
        return w;
    endfunction

    function automatic t_in_word make_cmd(input logic [7:0] chan, input logic [7:0] lvl);
        t_in_word w;
        w.req_type      = REQ_CMD;
        w.channel_index = chan;
        w.level_value   = lvl;
        w.link_up       = 1'($urandom);
        return w;
    endfunction

    // Random word: mostly ticks, commands mostly to real channels.
    function automatic t_in_word random_word(input int tick_pct);
        logic [7:0] chan;
        logic [7:0] lvl;
        int         pick;
        if ($urandom_range(99) < tick_pct)
            return make_tick($urandom_range(99) < 70);
        chan = ($urandom_range(99) < 85) ? 8'($urandom_range(NCH - 1)) : 8'($urandom);
        pick = $urandom_range(9);
        lvl  = (pick < 2) ? 8'd0 : (pick < 4) ? 8'd255 : 8'($urandom);
        return make_cmd(chan, lvl);
    endfunction

    // Result checker.
    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_pwm_words.size() == 0) begin
                $display("%0t: result word with none expected, got %h", $time, o_out_word);
                mismatch_count++;
            end else begin
                want = pending_pwm_words.pop_front();
                if (o_out_word.channel_outputs !== want.channel_outputs) begin
                    $display("%0t: channel_outputs expected %h, got %h", $time,
                             want.channel_outputs, o_out_word.channel_outputs);
                    mismatch_count++;
                end
                if (o_out_word.ping_request !== want.ping_request) begin
                    $display("%0t: ping_request expected %b, got %b", $time,
                             want.ping_request, o_out_word.ping_request);
                    mismatch_count++;
                end
                if (o_out_word.reconnect_request !== want.reconnect_request) begin
                    $display("%0t: reconnect_request expected %b, got %b", $time,
                             want.reconnect_request, o_out_word.reconnect_request);
                    mismatch_count++;
                end
            end
        end
    end

    // Receiver stall generator, with a counted hold-off stretch on request.
    always @(posedge i_clk) begin
        if (hold_start) begin
            hold_left  = HOLD_CYCLES;
            hold_start = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (no_idle) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(99) < 17);
        end
    end

    // Field extremes, ignored channels, level zero and the keepalive sequence.
    task automatic test_directed_commands();
        write_registers(16'd1, 32'd2);
        send_word(make_cmd(8'd0, 8'd255));
        send_word(make_cmd(8'd16, 8'd1));
        send_word(make_cmd(8'd5, 8'd0));
        send_word(make_cmd(8'd17, 8'd200));
        send_word(make_cmd(8'd255, 8'd255));
        send_word(make_cmd(8'd8, 8'd128));
        // Ping with the link up, then a reconnect when no command follows.
        send_word(make_tick(1'b1));
        send_word(make_tick(1'b1));
        send_word(make_tick(1'b0));
        send_word(make_tick(1'b0));
        // Ping suppressed with the link down.
        send_word(make_tick(1'b0));
        send_word(make_tick(1'b0));
        // An ignored channel still answers the outstanding ping.
        send_word(make_cmd(8'd170, 8'd85));
        send_word(make_tick(1'b1));
        send_word(make_tick(1'b1));
        drain_results();
    endtask

    // Zero in either register behaves as one: every tick steps and checks.
    task automatic test_keepalive_zero_registers();
        write_registers(16'd0, 32'd0);
        for (int k = 0; k < 8; k++)
            send_word(make_tick(k[0]));
        drain_results();
    endtask

    // Random words through a series of register settings.
    task automatic test_random_settings();
        logic [DIV_W-1:0]    div_set [8] = '{16'd1, 16'd1, 16'd2, 16'd65535,
                                             16'd3, 16'd1, 16'd1, 16'd5};
        logic [PERIOD_W-1:0] per_set [8] = '{32'd125, 32'd1, 32'd3, 32'hFFFF_FFFF,
                                             32'd7, 32'd40, 32'd2, 32'd17};
        for (int p = 0; p < 8; p++) begin
            write_registers(div_set[p], per_set[p]);
            no_idle = (p == 5);
            for (int k = 0; k < 115; k++) begin
                send_word(random_word(80));
                // Midway through each setting the sender pauses until the output is empty.
                if (k == 60)
                    drain_results();
            end
            drain_results();
            no_idle = 1'b0;
        end
    endtask

    // Receiver holds off long enough for the block to stall its input.
    task automatic test_output_backpressure();
        write_registers(16'd1, 32'd3);
        hold_start = 1'b1;
        for (int k = 0; k < 30; k++)
            send_word(random_word(70));
        drain_results();
    endtask

    initial begin
        for (int n = 0; n < NCH; n++)
            chan_level[n] = '0;
        chan_high        = '1;
        frame_phase      = '0;
        prescale_cnt     = '0;
        keepalive_cnt    = '0;
        ping_outstanding = 1'b0;
        phase_div_reg    = PHASE_DIV_RST;
        check_per_reg    = CHECK_PER_RST;

        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_out_stall <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= CFG_PHASE_DIV;
        i_cfg_data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_commands();
        test_keepalive_zero_registers();
        test_random_settings();
        test_output_backpressure();

        repeat (4) @(posedge i_clk);
        if (mismatch_count == 0 && pending_pwm_words.size() == 0) begin
            $display("multichannel_pwm_with_keepalive_top_tb OK");
        end else begin
            $display("multichannel_pwm_with_keepalive_top_tb NOT OK");
        end
        $finish;
    end

    // Overall time limit.
    initial begin
        #2000000;
        $display("multichannel_pwm_with_keepalive_top_tb NOT OK");
        $finish;
    end

endmodule

FILE: files.f
rtl/mcpwm_pkg.sv
rtl/mcpwm_core.sv
rtl/multichannel_pwm_with_keepalive_top.sv
rtl/mcpwm_checker.sv
test/multichannel_pwm_with_keepalive_top_tb.sv
